// ----- sv/multi_preset_crc_engine_assert.svh -----
// Assertion macros shared by the CRC engine RTL.
`ifndef MULTI_PRESET_CRC_ENGINE_ASSERT_SVH
`define MULTI_PRESET_CRC_ENGINE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MPCE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MPCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mpce_pkg.sv -----
// Package with CRC preset table, byte update function and register constants.
package mpce_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE = '0;

    localparam logic [3:0] MODE_CRC32   = 4'd13;
    localparam logic [3:0] MODE_INVALID = 4'd15;

    typedef struct packed {
        logic [31:0] poly_al;   // normal polynomial, left aligned to bit 31
        logic [31:0] rpoly;     // reflected polynomial, right aligned
        logic        refl;
        logic [4:0]  lshift;    // 32 minus preset width
        logic [31:0] mask;
        logic [31:0] init;
        logic [31:0] xorout;
    } preset_t;

    function automatic preset_t crc_preset(logic [3:0] mode);
        preset_t p;
        p = '0;
        unique case (mode)
            4'd0:    p = '{32'h0700_0000, 32'h0000_00E0, 1'b0, 5'd24, 32'h0000_00FF,
                           32'h0000_0000, 32'h0000_0000};
            4'd1:    p = '{32'h0700_0000, 32'h0000_00E0, 1'b0, 5'd24, 32'h0000_00FF,
                           32'h0000_0000, 32'h0000_0055};
            4'd2:    p = '{32'h0700_0000, 32'h0000_00E0, 1'b1, 5'd24, 32'h0000_00FF,
                           32'h0000_00FF, 32'h0000_0000};
            4'd3:    p = '{32'h3100_0000, 32'h0000_008C, 1'b1, 5'd24, 32'h0000_00FF,
                           32'h0000_0000, 32'h0000_0000};
            4'd4:    p = '{32'h8005_0000, 32'h0000_A001, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_0000, 32'h0000_0000};
            4'd5:    p = '{32'h8005_0000, 32'h0000_A001, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_0000, 32'h0000_FFFF};
            4'd6:    p = '{32'h8005_0000, 32'h0000_A001, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_FFFF, 32'h0000_FFFF};
            4'd7:    p = '{32'h8005_0000, 32'h0000_A001, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_FFFF, 32'h0000_0000};
            4'd8:    p = '{32'h1021_0000, 32'h0000_8408, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_0000, 32'h0000_0000};
            4'd9:    p = '{32'h1021_0000, 32'h0000_8408, 1'b0, 5'd16, 32'h0000_FFFF,
                           32'h0000_FFFF, 32'h0000_0000};
            4'd10:   p = '{32'h1021_0000, 32'h0000_8408, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_FFFF, 32'h0000_FFFF};
            4'd11:   p = '{32'h1021_0000, 32'h0000_8408, 1'b0, 5'd16, 32'h0000_FFFF,
                           32'h0000_0000, 32'h0000_0000};
            4'd12:   p = '{32'h3D65_0000, 32'h0000_A6BC, 1'b1, 5'd16, 32'h0000_FFFF,
                           32'h0000_0000, 32'h0000_FFFF};
            4'd14:   p = '{32'h04C1_1DB7, 32'hEDB8_8320, 1'b0, 5'd0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'h0000_0000};
            default: p = '{32'h04C1_1DB7, 32'hEDB8_8320, 1'b1, 5'd0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF};
        endcase
        return p;
    endfunction

    // Absorb one byte: eight bit times of shift and conditional XOR.
    // Non-reflected presets run left aligned so one datapath serves every width.
    function automatic logic [31:0] crc_absorb(preset_t p, logic [31:0] crc_in,
                                               logic [7:0] data);
        logic [31:0] c;
        c = crc_in & p.mask;
        if (p.refl)
        begin
            c = c ^ {24'h0, data};
            for (int b = 0; b < 8; b++)
            begin
                c = c[0] ? ((c >> 1) ^ p.rpoly) : (c >> 1);
            end
        end
        else
        begin
            c = c << p.lshift;
            c = c ^ {data, 24'h0};
            for (int b = 0; b < 8; b++)
            begin
                c = c[31] ? ((c << 1) ^ p.poly_al) : (c << 1);
            end
            c = c >> p.lshift;
        end
        return c & p.mask;
    endfunction

endpackage

// ----- sv/mpce_byte_if.sv -----
// Input channel carrying one message byte and its framing flags per beat.
interface mpce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

// ----- sv/mpce_crc_if.sv -----
// Output channel carrying one final CRC value per beat.
interface mpce_crc_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink (input valid, input crc_value, output ready);
endinterface

// ----- sv/multi_preset_crc_engine.sv -----
// Byte-serial CRC engine with fifteen catalogue presets selected over APB.
//
// Usage:
//   data_in  : one message byte per beat, with first_byte (load preset init
//              before absorbing) and last_byte (emit the final CRC).
//   crc_out  : one beat per byte flagged last_byte, holding the CRC after the
//              final XOR, right aligned; bits above the preset width are zero.
//   APB      : register crc_mode at byte address 0 (reads back the preset).
//              A write of 15, or to byte addresses 4 to 7, is dropped.
// Pipeline: a byte is captured in the input register and absorbed from there
//   into the running CRC; a final byte's result is registered for crc_out.
// Throughput: one byte per clock while crc_out is not stalled. The running CRC
//   register closes a loop of eight shift/XOR bit times, which sets the cycle.
// Reset: crc_mode returns to 13 (CRC-32), the running CRC clears to zero and
//   both pipeline registers empty.
// Stall: while crc_out is stalled the result holds; non-final bytes keep
//   flowing, and a final byte waits in the input register until the result
//   slot frees, with data_in.ready held low while it waits.
`include "multi_preset_crc_engine_assert.svh"

module multi_preset_crc_engine
    import mpce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    mpce_byte_if.sink             data_in,
    mpce_crc_if.source            crc_out
);

    // Configuration register
    logic [3:0]           crc_mode_reg;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    logic       s1_go;

    // Running CRC and result stage
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        out_valid_reg;
    logic [31:0] out_crc_reg;
    logic        out_free;
    preset_t     preset;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == REG_CRC_MODE) ? {28'h0, crc_mode_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg <= MODE_CRC32;
        end
        else if (cfg_wr && (cfg_idx == REG_CRC_MODE) && (pwdata[3:0] != MODE_INVALID))
        begin
            crc_mode_reg <= pwdata[3:0];
        end
    end

    assign preset = crc_preset(crc_mode_reg);

    // A final byte needs the result slot; other bytes always advance.
    assign out_free      = !out_valid_reg || crc_out.ready;
    assign s1_go         = s1_valid_reg && (!s1_last_reg || out_free);
    assign data_in.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (data_in.ready)
        begin
            s1_valid_reg <= data_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_in.ready && data_in.valid)
        begin
            s1_byte_reg  <= data_in.data_byte;
            s1_first_reg <= data_in.first_byte;
            s1_last_reg  <= data_in.last_byte;
        end
    end

    // Load the preset init on a first byte, then absorb the byte.
    assign crc_next = crc_absorb(preset, s1_first_reg ? preset.init : crc_reg, s1_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (s1_go)
        begin
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_go && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_crc_reg <= (crc_next ^ preset.xorout) & preset.mask;
        end
    end

    assign crc_out.valid     = out_valid_reg;
    assign crc_out.crc_value = out_crc_reg;

    `MPCE_ASSERT_ALWAYS(a_mode_legal, crc_mode_reg != MODE_INVALID, "crc_mode holds code 15")
    `MPCE_ASSERT_ALWAYS(a_out_width,
        !out_valid_reg || ((out_crc_reg & ~preset.mask) == 32'h0),
        "result has bits above preset width")
    `MPCE_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_go,
        s1_valid_reg && $stable(s1_byte_reg) && s1_last_reg,
        "stalled input stage lost its byte")

endmodule
